// ===== sv/acdr_pkg.sv =====
// ----------------------------------------------------------------------------
// acdr_pkg: shared constants and types for the averaged current duty regulator
// Widths of the sample ring, the scaling datapath and the current divider.
// ----------------------------------------------------------------------------
`default_nettype none

package acdr_pkg;

  localparam int FILTER_DEPTH = 32;
  localparam int PWM_BITS     = 9;
  localparam int ADC_BITS     = 12;

  localparam int PTR_BITS   = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(FILTER_DEPTH + 1);
  localparam int SUM_BITS   = $clog2((2**ADC_BITS - 1) * FILTER_DEPTH + 1);

  localparam int CUR_BITS    = 14;
  localparam int TARGET_BITS = 14;
  localparam int GAIN_BITS   = 16;
  localparam int SCALE_BITS  = 16;
  localparam int SCALE_FRAC  = 12;
  localparam int DUTY_FRAC   = 16;
  localparam int PCT_BITS    = 7;
  localparam int PCT_FULL    = 100;

  localparam int CUR_MAX    = 2**CUR_BITS - 1;
  localparam int DUTY_MAX   = 2**PWM_BITS - 1;
  localparam int DUTY_START = (255 > DUTY_MAX) ? DUTY_MAX : 255;

  // scaling product and its rounded, shifted form
  localparam int PROD_BITS = SUM_BITS + SCALE_BITS;
  localparam int NUM2_BITS = PROD_BITS + 1 - SCALE_FRAC;

  // duty accumulator and percent path
  localparam int ACC_BITS   = PWM_BITS + DUTY_FRAC;
  localparam int PM_BITS    = ACC_BITS + 7;
  localparam int PCTX_BITS  = PM_BITS + 1 - DUTY_FRAC;
  localparam int ERR_BITS   = CUR_BITS + 1;
  localparam int EPROD_BITS = ERR_BITS + GAIN_BITS + 1;
  localparam int SUMA_BITS  = EPROD_BITS + 1;

  // divide by full-scale duty as a reciprocal multiply, exact over PCTX_BITS
  localparam int PCT_SHIFT  = PCTX_BITS + PWM_BITS;
  localparam int PCT_RECIP  = (2**PCT_SHIFT + DUTY_MAX - 1) / DUTY_MAX;
  localparam int RECIP_BITS = $clog2(PCT_RECIP + 1);
  localparam int PQ_BITS    = PCTX_BITS + RECIP_BITS;

  // current divider
  localparam int DIV_W     = NUM2_BITS;
  localparam int DVS_W     = COUNT_BITS;
  localparam int QUO_BITS  = CUR_BITS;
  localparam int STEP_BITS = $clog2(QUO_BITS + 1);
  localparam int RM_W      = (DIV_W > DVS_W + QUO_BITS) ? DIV_W : DVS_W + QUO_BITS;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REGEN  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIXED  = 3'd4;

  typedef struct packed {
    logic rd;    // read the slot under the pointer
    logic upd;   // write the new sample, update sum and pointer
  } ring_ctl_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DVS_W-1:0]     divisor;
    logic [STEP_BITS-1:0] steps;
  } div_req_t;

endpackage

`default_nettype wire

// ===== sv/acdr_ring.sv =====
// ----------------------------------------------------------------------------
// acdr_ring: moving-average sample ring
// Synchronous sample memory with per-entry valid bits, ring pointer, running
// sum, fill flag and the sample count used as the averaging divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module acdr_ring
  import acdr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ring_ctl_t             ctl_i,
  input  wire logic [ADC_BITS-1:0]   sample_i,
  output logic      [SUM_BITS-1:0]   sum_o,
  output logic      [COUNT_BITS-1:0] count_o,
  output logic                       filled_o
);

  logic [ADC_BITS-1:0]     mem [FILTER_DEPTH];
  logic [ADC_BITS-1:0]     rd_data_q;
  logic [FILTER_DEPTH-1:0] vld_q;
  logic [PTR_BITS-1:0]     ptr_q, ptr_d;
  logic [SUM_BITS-1:0]     sum_q, sum_d;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic                    filled_q, filled_d;
  logic [ADC_BITS-1:0]     old_w;
  logic                    wrap_w;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_data_q <= mem[ptr_q];
    end
    if (ctl_i.upd) begin
      mem[ptr_q] <= sample_i;
    end
  end

  // never-written entries read as zero
  assign old_w  = vld_q[ptr_q] ? rd_data_q : '0;
  assign wrap_w = (ptr_q == PTR_BITS'(FILTER_DEPTH - 1));

  always_comb begin
    sum_d    = sum_q - SUM_BITS'(old_w) + SUM_BITS'(sample_i);
    ptr_d    = wrap_w ? '0 : PTR_BITS'(ptr_q + 1'b1);
    filled_d = filled_q | wrap_w;
    count_d  = filled_d ? COUNT_BITS'(FILTER_DEPTH)
                        : COUNT_BITS'(COUNT_BITS'(ptr_q) + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      ptr_q    <= '0;
      sum_q    <= '0;
      count_q  <= COUNT_BITS'(1);
      filled_q <= 1'b0;
    end else if (ctl_i.upd) begin
      vld_q[ptr_q] <= 1'b1;
      ptr_q        <= ptr_d;
      sum_q        <= sum_d;
      count_q      <= count_d;
      filled_q     <= filled_d;
    end
  end

  assign sum_o    = sum_q;
  assign count_o  = count_q;
  assign filled_o = filled_q;

endmodule

`default_nettype wire

// ===== sv/acdr_div.sv =====
// ----------------------------------------------------------------------------
// acdr_div: restoring divider
// One quotient bit per cycle; the caller gives the number of quotient bits
// and guarantees the dividend is below divisor << steps.
// ----------------------------------------------------------------------------
`default_nettype none

module acdr_div
  import acdr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire div_req_t            req_i,
  output logic                     busy_o,
  output logic      [QUO_BITS-1:0] quo_o
);

  logic                 busy_q;
  logic [STEP_BITS-1:0] cnt_q;
  logic [RM_W-1:0]      rem_q;
  logic [RM_W-1:0]      dsh_q;
  logic [QUO_BITS-1:0]  quo_q;
  logic                 ge_w;

  assign ge_w = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= STEP_BITS'(cnt_q - 1'b1);
      if (cnt_q == STEP_BITS'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= RM_W'(req_i.dividend);
      dsh_q <= RM_W'(req_i.divisor) << (req_i.steps - 1'b1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge_w) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QUO_BITS-2:0], ge_w};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== sv/averaged_current_duty_regulator.sv =====
// ----------------------------------------------------------------------------
// averaged_current_duty_regulator: moving-average current regulator
// Averages shunt samples over a ring, scales to mA and integrates the error
// into a clamped Q9.16 duty; reports current, PWM duty, percent and fill.
// ----------------------------------------------------------------------------
//  channel   signals                                   dir
//  in        in_valid_i, in_stall_o, adc_sample_i      sample in
//  out       out_valid_o, out_stall_i, measured_current_ma_o,
//            pwm_duty_o, duty_percent_o, filter_full_o result out
//  cfg       cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i  register write
//
//  One transaction at a time: the result is loaded into the output register
//  before the next sample is taken; a saturating current skips the divider.
//  The current divider sets the pace with its 14 quotient bits; the rest is
//  one memory read, four multiplies, the accumulate and the load.
//  Reset clears the ring valid bits at once, so no clearing pass. A stalled
//  result is held in the output register while the next sample goes on.
// ----------------------------------------------------------------------------
`default_nettype none

module averaged_current_duty_regulator
  import acdr_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [ADC_BITS-1:0]      adc_sample_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic      [CUR_BITS-1:0]      measured_current_ma_o,
  output logic      [PWM_BITS-1:0]      pwm_duty_o,
  output logic      [PCT_BITS-1:0]      duty_percent_o,
  output logic                          filter_full_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_DIVC = 4'd4;
  localparam logic [3:0] S_ERR  = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_PCT  = 4'd7;
  localparam logic [3:0] S_PCTD = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic signed [SUMA_BITS-1:0] ACC_TOP_S =
    SUMA_BITS'(DUTY_MAX) << DUTY_FRAC;
  localparam logic [ACC_BITS-1:0] ACC_TOP   = ACC_BITS'(DUTY_MAX) << DUTY_FRAC;
  localparam logic [ACC_BITS-1:0] ACC_RESET = ACC_BITS'(DUTY_START) << DUTY_FRAC;
  localparam int                  SATW      = NUM2_BITS + CUR_BITS;

  // configuration registers
  logic [TARGET_BITS-1:0] target_q;
  logic [GAIN_BITS-1:0]   gain_q;
  logic [SCALE_BITS-1:0]  scale_q;
  logic                   regen_q;
  logic [PWM_BITS-1:0]    fixed_q;

  logic [3:0]                    state_q, state_d;
  logic [ADC_BITS-1:0]           sample_q;
  logic [PROD_BITS-1:0]          prod_q;
  logic [CUR_BITS-1:0]           cur_q;
  logic signed [EPROD_BITS-1:0]  eprod_q;
  logic [ACC_BITS-1:0]           acc_q, acc_d;
  logic [PM_BITS-1:0]            pm_q;
  logic [PQ_BITS-1:0]            pq_q;

  logic                  out_valid_q;
  logic [CUR_BITS-1:0]   out_cur_q;
  logic [PWM_BITS-1:0]   out_duty_q;
  logic [PCT_BITS-1:0]   out_pct_q;
  logic                  out_full_q;

  ring_ctl_t             ring_ctl;
  logic [SUM_BITS-1:0]   ring_sum;
  logic [COUNT_BITS-1:0] ring_count;
  logic                  ring_filled;

  div_req_t              div_req;
  logic                  div_busy;
  logic [QUO_BITS-1:0]   div_quo;

  logic                         in_acc_w;
  logic                         out_free_w;
  logic [PROD_BITS:0]           num_w;
  logic [NUM2_BITS-1:0]         num2_w;
  logic                         sat_w;
  logic signed [ERR_BITS-1:0]   err_w;
  logic signed [SUMA_BITS-1:0]  accs_w;
  logic [PM_BITS:0]             pmr_w;
  logic [PCTX_BITS-1:0]         pctx_w;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc_w    = in_valid_i && !in_stall_o;
  assign out_free_w  = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  acdr_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ring_ctl),
    .sample_i (sample_q),
    .sum_o    (ring_sum),
    .count_o  (ring_count),
    .filled_o (ring_filled)
  );

  acdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // rounding folded in before the shift: floor((p + c*2048) / 4096) / c
  assign num_w  = {1'b0, prod_q}
                + ((PROD_BITS + 1)'(ring_count) << (SCALE_FRAC - 1));
  assign num2_w = num_w[PROD_BITS:SCALE_FRAC];
  assign sat_w  = (SATW'(num2_w) >= (SATW'(ring_count) << CUR_BITS));

  assign err_w  = $signed({1'b0, target_q}) - $signed({1'b0, cur_q});
  assign accs_w = SUMA_BITS'($signed({1'b0, acc_q})) + SUMA_BITS'(eprod_q);

  always_comb begin
    if (accs_w < 0) begin
      acc_d = '0;
    end else if (accs_w > ACC_TOP_S) begin
      acc_d = ACC_TOP;
    end else begin
      acc_d = accs_w[ACC_BITS-1:0];
    end
  end

  assign pmr_w  = {1'b0, pm_q} + ((PM_BITS + 1)'(DUTY_MAX) << (DUTY_FRAC - 1));
  assign pctx_w = pmr_w[PM_BITS:DUTY_FRAC];

  always_comb begin
    state_d          = state_q;
    ring_ctl.rd      = 1'b0;
    ring_ctl.upd     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(num2_w);
    div_req.divisor  = DVS_W'(ring_count);
    div_req.steps    = STEP_BITS'(CUR_BITS);
    case (state_q)
      S_IDLE: begin
        if (in_acc_w) begin
          ring_ctl.rd = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        ring_ctl.upd = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL:  state_d = S_NORM;
      S_NORM: begin
        if (sat_w) begin
          state_d = S_ERR;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIVC;
        end
      end
      S_DIVC: begin
        if (!div_busy) begin
          state_d = S_ERR;
        end
      end
      S_ERR:  state_d = S_ACC;
      S_ACC:  state_d = S_PCT;
      S_PCT:  state_d = S_PCTD;
      S_PCTD: state_d = S_OUT;
      S_OUT: begin
        if (out_free_w) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= ACC_RESET;
      target_q    <= TARGET_BITS'(1000);
      gain_q      <= GAIN_BITS'(6554);
      scale_q     <= SCALE_BITS'(10429);
      regen_q     <= 1'b0;
      fixed_q     <= PWM_BITS'(255);
    end else begin
      state_q <= state_d;
      if (state_q == S_ACC) begin
        acc_q <= acc_d;
      end
      if (state_q == S_OUT && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TARGET: target_q <= cfg_data_i[TARGET_BITS-1:0];
          CFG_GAIN:   gain_q   <= cfg_data_i[GAIN_BITS-1:0];
          CFG_SCALE:  scale_q  <= cfg_data_i[SCALE_BITS-1:0];
          CFG_REGEN:  regen_q  <= cfg_data_i[0];
          CFG_FIXED:  fixed_q  <= cfg_data_i[PWM_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc_w) begin
      sample_q <= adc_sample_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_BITS'(ring_sum) * PROD_BITS'(scale_q);
    end
    if (state_q == S_NORM && sat_w) begin
      cur_q <= CUR_BITS'(CUR_MAX);
    end else if (state_q == S_DIVC && !div_busy) begin
      cur_q <= div_quo;
    end
    if (state_q == S_ERR) begin
      eprod_q <= EPROD_BITS'(err_w) * EPROD_BITS'($signed({1'b0, gain_q}));
    end
    if (state_q == S_PCT) begin
      pm_q <= PM_BITS'(acc_q) * PM_BITS'(PCT_FULL);
    end
    if (state_q == S_PCTD) begin
      pq_q <= PQ_BITS'(pctx_w) * PQ_BITS'(PCT_RECIP);
    end
    if (state_q == S_OUT && state_d == S_IDLE) begin
      out_cur_q  <= cur_q;
      out_duty_q <= regen_q ? acc_q[ACC_BITS-1:DUTY_FRAC] : fixed_q;
      out_pct_q  <= pq_q[PCT_SHIFT +: PCT_BITS];
      out_full_q <= ring_filled;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign measured_current_ma_o = out_cur_q;
  assign pwm_duty_o            = out_duty_q;
  assign duty_percent_o        = out_pct_q;
  assign filter_full_o         = out_full_q;

endmodule

`default_nettype wire

// ===== bench/tb_averaged_current_duty_regulator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_averaged_current_duty_regulator: self-checking bench for the regulator
// Streams converter samples through the block under bursty input and a
// stalling output. A scoreboard tracks its own copy of the averaging ring,
// scaling and duty integrator, and compares every reading as it leaves.
// ----------------------------------------------------------------------------

module tb_averaged_current_duty_regulator;
  import acdr_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AFTER   = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 135;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [CUR_BITS-1:0] current;
    logic [PWM_BITS-1:0] duty;
    logic [PCT_BITS-1:0] percent;
    logic                full;
  } reading_t;

  class reading_scoreboard;
    reading_t expected_readings[$];
    int failures;
    int results_seen;
    bit [TARGET_BITS-1:0] target_ma;
    bit [GAIN_BITS-1:0]   gain;
    bit [SCALE_BITS-1:0]  scale;
    bit                   regulate;
    bit [PWM_BITS-1:0]    fixed_duty;
    bit [ADC_BITS-1:0]    ring [FILTER_DEPTH];
    int unsigned          ptr;
    int unsigned          sum;
    bit                   filled;
    longint               acc;

    function new();
      target_ma  = 1000;
      gain       = 6554;
      scale      = 10429;
      regulate   = 1'b0;
      fixed_duty = 255;
      foreach (ring[i]) ring[i] = '0;
      ptr          = 0;
      sum          = 0;
      filled       = 1'b0;
      acc          = longint'(DUTY_START) << DUTY_FRAC;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_BITS-1:0] idx, bit [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_TARGET: target_ma  = data[TARGET_BITS-1:0];
        CFG_GAIN:   gain       = data[GAIN_BITS-1:0];
        CFG_SCALE:  scale      = data[SCALE_BITS-1:0];
        CFG_REGEN:  regulate   = data[0];
        CFG_FIXED:  fixed_duty = data[PWM_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(bit [ADC_BITS-1:0] adc);
      reading_t r;
      u64_t     count;
      u64_t     den;
      u64_t     cur;
      u64_t     pct_den;
      u64_t     pct;
      longint   top;
      top = longint'(DUTY_MAX) << DUTY_FRAC;
      sum = sum - ring[ptr] + adc;
      ring[ptr] = adc;
      ptr++;
      if (ptr == FILTER_DEPTH) begin
        ptr    = 0;
        filled = 1'b1;
      end
      // divisor is the number of samples actually held during warm-up
      count = filled ? FILTER_DEPTH : ptr;
      den   = count << SCALE_FRAC;
      cur   = (u64_t'(sum) * scale + den / 2) / den;
      if (cur > CUR_MAX) cur = CUR_MAX;
      acc = acc + (longint'(target_ma) - longint'(cur)) * longint'(gain);
      if (acc > top) acc = top;
      if (acc < 0) acc = 0;
      pct_den   = u64_t'(DUTY_MAX) << DUTY_FRAC;
      pct       = (u64_t'(acc) * PCT_FULL + pct_den / 2) / pct_den;
      r.current = cur[CUR_BITS-1:0];
      r.duty    = regulate ? acc[DUTY_FRAC +: PWM_BITS] : fixed_duty;
      r.percent = pct[PCT_BITS-1:0];
      r.full    = filled;
      expected_readings.push_back(r);
    endfunction

    function void check_reading(logic [CUR_BITS-1:0] cur, logic [PWM_BITS-1:0] duty,
                                logic [PCT_BITS-1:0] pct, logic full);
      reading_t e;
      results_seen++;
      if (expected_readings.size() == 0) begin
        $error("reading with no sample outstanding: measured_current_ma %0d", cur);
        failures++;
        return;
      end
      e = expected_readings.pop_front();
      if (cur !== e.current) begin
        $error("measured_current_ma: expected %0d, actual %0d", e.current, cur);
        failures++;
      end
      if (duty !== e.duty) begin
        $error("pwm_duty: expected %0d, actual %0d", e.duty, duty);
        failures++;
      end
      if (pct !== e.percent) begin
        $error("duty_percent: expected %0d, actual %0d", e.percent, pct);
        failures++;
      end
      if (full !== e.full) begin
        $error("filter_full: expected %0d, actual %0d", e.full, full);
        failures++;
      end
    endfunction
  endclass

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic [ADC_BITS-1:0]      adc_sample_i = '0;
  logic                     out_stall_i  = 1'b0;
  logic                     cfg_valid_i  = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i  = CFG_TARGET;
  logic [CFG_DATA_BITS-1:0] cfg_data_i   = '0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [CUR_BITS-1:0]      measured_current_ma_o;
  logic [PWM_BITS-1:0]      pwm_duty_o;
  logic [PCT_BITS-1:0]      duty_percent_o;
  logic                     filter_full_o;
  logic                     cfg_ready_o;

  reading_scoreboard sb = new();
  int  idle_cycles = 0;
  int  burst_left  = 0;
  bit  hold_done   = 1'b0;

  averaged_current_duty_regulator u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .adc_sample_i          (adc_sample_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .measured_current_ma_o (measured_current_ma_o),
    .pwm_duty_o            (pwm_duty_o),
    .duty_percent_o        (duty_percent_o),
    .filter_full_o         (filter_full_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // transaction monitor: all three channels, plus the activity count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_sample(adc_sample_i);
      if (out_valid_o && !out_stall_i)
        sb.check_reading(measured_current_ma_o, pwm_duty_o, duty_percent_o, filter_full_o);
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // output back-pressure: changing patterns, and one long hold to fill the block
  initial begin
    int mode;
    int span;
    int period;
    int on_len;
    int tick;
    tick = 0;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(32, 300);
      period = $urandom_range(2, 12);
      on_len = $urandom_range(1, period - 1);
      repeat (span) begin
        @(negedge clk_i);
        if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_done = 1'b1;
        end
        tick++;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= $urandom_range(0, 1);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ((tick % period) < on_len);
        endcase
      end
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(input logic [ADC_BITS-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    adc_sample_i <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid and let every outstanding reading leave, so the block is idle
  task automatic end_phase();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
  endtask

  // value in the low bits, random junk above the register width
  function automatic logic [CFG_DATA_BITS-1:0] with_junk(int unsigned value, int width);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'($urandom);
    return CFG_DATA_BITS'((u64_t'(junk) << width) | value);
  endfunction

  task automatic apply_random_settings();
    int unsigned v;
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = CUR_MAX;
      2: v = $urandom_range(300, 5000);
      default: v = $urandom_range(0, CUR_MAX);
    endcase
    write_cfg(CFG_TARGET, with_junk(v, TARGET_BITS));
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 16'hFFFF;
      2, 3: v = $urandom_range(1, 400);
      default: v = $urandom_range(0, 16'hFFFF);
    endcase
    write_cfg(CFG_GAIN, CFG_DATA_BITS'(v));
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 16'hFFFF;
      2, 3: v = $urandom_range(8000, 13000);
      default: v = $urandom_range(0, 16'hFFFF);
    endcase
    write_cfg(CFG_SCALE, CFG_DATA_BITS'(v));
    write_cfg(CFG_REGEN, with_junk($urandom_range(0, 1), 1));
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = DUTY_MAX;
      default: v = $urandom_range(0, DUTY_MAX);
    endcase
    write_cfg(CFG_FIXED, with_junk(v, PWM_BITS));
    if ($urandom_range(0, 2) == 0)
      write_cfg(CFG_IDX_BITS'($urandom_range(int'(CFG_FIXED) + 1, 2**CFG_IDX_BITS - 1)),
                CFG_DATA_BITS'($urandom));
  endtask

  task automatic random_phase(input int n);
    int style;
    int level;
    int noise;
    int v;
    style = $urandom_range(0, 3);
    level = $urandom_range(0, 4095);
    noise = $urandom_range(0, 64);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        style = $urandom_range(0, 3);
        level = $urandom_range(0, 4095);
      end
      case (style)
        0: v = $urandom_range(0, 4095);
        1: v = level + $urandom_range(0, 2 * noise) - noise;
        2: v = $urandom_range(0, 1) ? 4095 - $urandom_range(0, 3) : $urandom_range(0, 3);
        default: v = level + i * noise;
      endcase
      if (style == 1) v = (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
      send_sample(v[ADC_BITS-1:0]);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // warm-up under reset settings: divisor tracks the sample count
    send_sample(0);
    send_sample(4095);
    send_sample(4095);
    send_sample(1);
    send_sample(2048);
    end_phase();

    // full-scale target and scale: earlier samples still in the ring saturate the current, so the error is zero
    write_cfg(CFG_REGEN, 1);
    write_cfg(CFG_TARGET, CUR_MAX);
    write_cfg(CFG_GAIN, 16'hFFFF);
    write_cfg(CFG_SCALE, 16'hFFFF);
    repeat (3) send_sample(0);
    end_phase();

    // saturated current against a zero target clamps the accumulator at zero
    write_cfg(CFG_TARGET, 0);
    repeat (3) send_sample(4095);
    end_phase();

    // zero scale reads as no current; zero gain freezes the duty
    write_cfg(CFG_TARGET, 5000);
    write_cfg(CFG_GAIN, 0);
    write_cfg(CFG_SCALE, 0);
    send_sample(4095);
    send_sample(100);
    end_phase();

    // fixed duty, junk above register widths, writes to unused indexes
    write_cfg(CFG_REGEN, 16'hFFFE);
    write_cfg(CFG_FIXED, 16'hFFFF);
    write_cfg(CFG_TARGET, 16'hC3E8);
    write_cfg(CFG_GAIN, 16'h0100);
    for (int i = int'(CFG_FIXED) + 1; i < 2**CFG_IDX_BITS; i++)
      write_cfg(CFG_IDX_BITS'(i), CFG_DATA_BITS'($urandom));
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'hFFF);
    end_phase();

    write_cfg(CFG_FIXED, 16'hFE00);
    write_cfg(CFG_SCALE, 10429);
    send_sample(0);
    send_sample(2000);
    send_sample(4000);
    end_phase();

    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_random_settings();
      random_phase(PHASE_ITEMS);
      end_phase();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/acdr_pkg.sv
sv/acdr_ring.sv
sv/acdr_div.sv
sv/averaged_current_duty_regulator.sv
bench/tb_averaged_current_duty_regulator.sv
